// ===== sv/mexp_pkg.sv =====
// Shared types, constants and the control store of the modular exponentiation block.
// No dependencies; every other file imports this package.
package mexp_pkg;

	localparam int BASE_W  = 32;   // width of the base field
	localparam int EXPIN_W = 64;   // width of the exponent field on the port
	localparam int RES_W   = 32;   // width of the residue field
	localparam int CNT_W   = 6;    // multiplier bit counter, holds up to BASE_W
	localparam int STEP_W  = 4;

	typedef logic [STEP_W-1:0] step_t;

	// datapath action of one control word
	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_TAKE,    // accept an input beat
		ACT_CHECK,   // settle the zero exponent and zero modulus cases
		ACT_LD_RED,  // load multiplier: base reduction
		ACT_MUL,     // one multiplier bit step
		ACT_WR_B,    // store reduced base, r = 1, arm bit counter
		ACT_LD_SQ,   // load multiplier: r * r
		ACT_WR_R,    // store multiplier result into r
		ACT_LD_MB,   // load multiplier: r * b
		ACT_NEXT,    // advance to the next exponent bit
		ACT_LD_RES,  // copy r into the result register
		ACT_EMIT     // hand the result to the output register
	} act_t;

	// jump condition; when true the sequencer jumps to the target
	typedef enum logic [2:0] {
		C_NEVER,
		C_NO_IN,
		C_TRIVIAL,
		C_MUL_MORE,
		C_EBIT_CLR,
		C_BITS_LEFT,
		C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		act_t  act;
		cond_t cond;
		step_t tgt;
		logic  ret;   // on fall-through return to the idle step
	} uword_t;

	typedef struct packed {
		logic load;
		logic run;
	} mm_ctl_t;

	localparam step_t ST_IDLE   = 4'd0;
	localparam step_t ST_CHECK  = 4'd1;
	localparam step_t ST_LD_RED = 4'd2;
	localparam step_t ST_RED    = 4'd3;
	localparam step_t ST_WR_B   = 4'd4;
	localparam step_t ST_LD_SQ  = 4'd5;
	localparam step_t ST_SQ     = 4'd6;
	localparam step_t ST_WR_SQ  = 4'd7;
	localparam step_t ST_LD_MB  = 4'd8;
	localparam step_t ST_MB     = 4'd9;
	localparam step_t ST_WR_MB  = 4'd10;
	localparam step_t ST_NEXT   = 4'd11;
	localparam step_t ST_LD_RES = 4'd12;
	localparam step_t ST_EMIT   = 4'd13;

	// control store: one word per step
	function automatic uword_t ucode(input step_t s);
		uword_t w;
		w = '{act: ACT_NONE, cond: C_NEVER, tgt: ST_IDLE, ret: 1'b1};
		unique case (s)
			ST_IDLE:   w = '{act: ACT_TAKE,   cond: C_NO_IN,     tgt: ST_IDLE,  ret: 1'b0};
			ST_CHECK:  w = '{act: ACT_CHECK,  cond: C_TRIVIAL,   tgt: ST_EMIT,  ret: 1'b0};
			ST_LD_RED: w = '{act: ACT_LD_RED, cond: C_NEVER,     tgt: ST_IDLE,  ret: 1'b0};
			ST_RED:    w = '{act: ACT_MUL,    cond: C_MUL_MORE,  tgt: ST_RED,   ret: 1'b0};
			ST_WR_B:   w = '{act: ACT_WR_B,   cond: C_NEVER,     tgt: ST_IDLE,  ret: 1'b0};
			ST_LD_SQ:  w = '{act: ACT_LD_SQ,  cond: C_NEVER,     tgt: ST_IDLE,  ret: 1'b0};
			ST_SQ:     w = '{act: ACT_MUL,    cond: C_MUL_MORE,  tgt: ST_SQ,    ret: 1'b0};
			ST_WR_SQ:  w = '{act: ACT_WR_R,   cond: C_EBIT_CLR,  tgt: ST_NEXT,  ret: 1'b0};
			ST_LD_MB:  w = '{act: ACT_LD_MB,  cond: C_NEVER,     tgt: ST_IDLE,  ret: 1'b0};
			ST_MB:     w = '{act: ACT_MUL,    cond: C_MUL_MORE,  tgt: ST_MB,    ret: 1'b0};
			ST_WR_MB:  w = '{act: ACT_WR_R,   cond: C_NEVER,     tgt: ST_IDLE,  ret: 1'b0};
			ST_NEXT:   w = '{act: ACT_NEXT,   cond: C_BITS_LEFT, tgt: ST_LD_SQ, ret: 1'b0};
			ST_LD_RES: w = '{act: ACT_LD_RES, cond: C_NEVER,     tgt: ST_IDLE,  ret: 1'b0};
			ST_EMIT:   w = '{act: ACT_EMIT,   cond: C_OUT_BUSY,  tgt: ST_EMIT,  ret: 1'b1};
			default:   w = '{act: ACT_NONE,   cond: C_NEVER,     tgt: ST_IDLE,  ret: 1'b1};
		endcase
		return w;
	endfunction

endpackage

// ===== sv/mexp_mulmod.sv =====
// Bit-serial modular multiplier: acc = x * y mod p, one bit of y per cycle, MSB first.
// Depends on mexp_pkg.
module mexp_mulmod import mexp_pkg::*; #(
	parameter int MOD_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mm_ctl_t              ctl,
	input  logic [MOD_WIDTH-1:0] x,
	input  logic [BASE_W-1:0]    y,      // left aligned, scanned from the top
	input  logic [CNT_W-1:0]     len,
	input  logic [MOD_WIDTH-1:0] p,
	output logic [MOD_WIDTH-1:0] acc,
	output logic                 more
);

	logic [MOD_WIDTH-1:0] acc_q;
	logic [MOD_WIDTH-1:0] x_q;
	logic [BASE_W-1:0]    y_q;
	logic [CNT_W-1:0]     cnt_q;

	logic [MOD_WIDTH+1:0] t;
	logic [MOD_WIDTH+2:0] d1;
	logic [MOD_WIDTH+2:0] d2;
	logic [MOD_WIDTH-1:0] acc_nx;

	// 2*acc + bit*x stays below 3p; subtract p and 2p side by side and pick
	always_comb begin
		t  = {1'b0, acc_q, 1'b0} + (y_q[BASE_W-1] ? {2'b00, x_q} : '0);
		d1 = {1'b0, t} - {3'b000, p};
		d2 = {1'b0, t} - {2'b00, p, 1'b0};
		priority if (!d2[MOD_WIDTH+2]) begin
			acc_nx = d2[MOD_WIDTH-1:0];
		end else if (!d1[MOD_WIDTH+2]) begin
			acc_nx = d1[MOD_WIDTH-1:0];
		end else begin
			acc_nx = t[MOD_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.load) begin
			cnt_q <= len;
		end else if (ctl.run) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			acc_q <= '0;
			x_q   <= x;
			y_q   <= y;
		end else if (ctl.run) begin
			acc_q <= acc_nx;
			y_q   <= y_q << 1;
		end
	end

	assign acc  = acc_q;
	assign more = (cnt_q != CNT_W'(1));

endmodule

// ===== sv/modular_exponentiation.sv =====
// Top level of the modular exponentiation block: residue = base ^ exponent mod modulus.
// Depends on mexp_pkg and mexp_mulmod.
//
// Usage
//   Write the modulus through cfg_we/cfg_wdata while the block is idle; it resets to 0.
//   Input beats carry base and exponent on s_tdata; each gives one output beat with the
//   residue on m_tdata and an error flag on m_tuser.
//   A zero exponent gives 1 without error. A zero modulus with a nonzero exponent gives
//   residue 0 with m_tuser high.
// Operation
//   A small microcoded sequencer drives one bit-serial modular multiplier. Reducing the
//   base comes first; each exponent bit then costs a square, a multiply when the bit
//   is set and an advance step. The trivial cases go straight from the check to the
//   output. The multiplier sets the rate: one item is worked at a time.
// Reset and stall
//   arst_n clears the sequencer, the output valid and the modulus. A finished result sits
//   in the output register until m_tready takes it, while the block already accepts and
//   works the next item; it holds that one at the end until the register is free.
module modular_exponentiation import mexp_pkg::*; #(
	parameter int MOD_WIDTH = 32,
	parameter int EXP_WIDTH = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [BASE_W-1:0]          cfg_wdata,   // modulus
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [BASE_W+EXPIN_W-1:0]  s_tdata,     // [31:0] base, [95:32] exponent
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [RES_W-1:0]           m_tdata,     // [31:0] residue
	output logic                       m_tuser      // [0] error
);

	localparam int BIT_W = $clog2(EXP_WIDTH + 1);

	// configuration
	logic [MOD_WIDTH-1:0] modulus_q;

	// sequencer
	step_t  step_q;
	step_t  step_nx;
	uword_t uw;
	logic   cond_hit;

	// datapath
	logic [BASE_W-1:0]    g_q;
	logic [EXP_WIDTH-1:0] e_q;
	logic [MOD_WIDTH-1:0] b_q;
	logic [MOD_WIDTH-1:0] r_q;
	logic [BIT_W-1:0]     bit_q;
	logic [MOD_WIDTH-1:0] res_q;
	logic                 err_q;

	// output register
	logic                 m_tvalid_q;
	logic [MOD_WIDTH-1:0] out_res_q;
	logic                 out_err_q;
	logic                 out_busy;
	logic                 emit;

	// multiplier
	mm_ctl_t              mm_ctl;
	logic [MOD_WIDTH-1:0] mm_x;
	logic [BASE_W-1:0]    mm_y;
	logic [CNT_W-1:0]     mm_len;
	logic [MOD_WIDTH-1:0] mm_acc;
	logic                 mm_more;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= '0;
		end else if (cfg_we) begin
			modulus_q <= cfg_wdata[MOD_WIDTH-1:0];
		end
	end

	// fetch the control word of the current step
	assign uw       = ucode(step_q);
	assign out_busy = m_tvalid_q && !m_tready;

	// evaluate the jump condition
	always_comb begin
		unique case (uw.cond)
			C_NEVER:     cond_hit = 1'b0;
			C_NO_IN:     cond_hit = !s_tvalid;
			C_TRIVIAL:   cond_hit = (e_q == '0) || (modulus_q == '0);
			C_MUL_MORE:  cond_hit = mm_more;
			C_EBIT_CLR:  cond_hit = !e_q[EXP_WIDTH-1];
			C_BITS_LEFT: cond_hit = (bit_q != BIT_W'(1));
			C_OUT_BUSY:  cond_hit = out_busy;
			default:     cond_hit = 1'b0;
		endcase
	end

	// next step: jump, return to idle, or advance
	always_comb begin
		priority if (cond_hit) begin
			step_nx = uw.tgt;
		end else if (uw.ret) begin
			step_nx = ST_IDLE;
		end else begin
			step_nx = step_q + step_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else begin
			step_q <= step_nx;
		end
	end

	assign s_tready = (uw.act == ACT_TAKE);
	assign emit     = (uw.act == ACT_EMIT) && !out_busy;

	// steer the multiplier operands from the control word
	always_comb begin
		mm_ctl.load = 1'b0;
		mm_ctl.run  = (uw.act == ACT_MUL);
		mm_x        = '0;
		mm_y        = '0;
		mm_len      = CNT_W'(MOD_WIDTH);
		unique case (uw.act)
			ACT_LD_RED: begin
				mm_ctl.load = 1'b1;
				mm_x        = MOD_WIDTH'(1);
				mm_y        = g_q;
				mm_len      = CNT_W'(BASE_W);
			end
			ACT_LD_SQ: begin
				mm_ctl.load = 1'b1;
				mm_x        = r_q;
				mm_y        = BASE_W'(r_q) << (BASE_W - MOD_WIDTH);
			end
			ACT_LD_MB: begin
				mm_ctl.load = 1'b1;
				mm_x        = r_q;
				mm_y        = BASE_W'(b_q) << (BASE_W - MOD_WIDTH);
			end
			default: begin
				mm_ctl.load = 1'b0;
			end
		endcase
	end

	mexp_mulmod #(
		.MOD_WIDTH(MOD_WIDTH)
	) u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mm_ctl),
		.x      (mm_x),
		.y      (mm_y),
		.len    (mm_len),
		.p      (modulus_q),
		.acc    (mm_acc),
		.more   (mm_more)
	);

	// working registers, written as the control word says
	always_ff @(posedge clk) begin
		unique case (uw.act)
			ACT_TAKE: begin
				if (s_tvalid) begin
					g_q <= s_tdata[BASE_W-1:0];
					e_q <= s_tdata[BASE_W +: EXP_WIDTH];
				end
			end
			ACT_CHECK: begin
				res_q <= (e_q == '0) ? MOD_WIDTH'(1) : '0;
				err_q <= (e_q != '0);
			end
			ACT_WR_B: begin
				b_q   <= mm_acc;
				r_q   <= MOD_WIDTH'(1);
				bit_q <= BIT_W'(EXP_WIDTH);
			end
			ACT_WR_R: begin
				r_q <= mm_acc;
			end
			ACT_NEXT: begin
				e_q   <= e_q << 1;
				bit_q <= bit_q - BIT_W'(1);
			end
			ACT_LD_RES: begin
				res_q <= r_q;
				err_q <= 1'b0;
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	// output register: hold the beat until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_res_q <= res_q;
			out_err_q <= err_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = RES_W'(out_res_q);
	assign m_tuser  = out_err_q;

	// an error beat carries a zero residue
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("error beat with nonzero residue");

	// a regular residue other than one lies below the modulus
	a_res_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser && m_tdata != RES_W'(1) |-> m_tdata < RES_W'(modulus_q))
		else $error("residue not reduced");

	// every multiplier step leaves a reduced accumulator
	a_acc_range: assert property (@(posedge clk) disable iff (!arst_n)
		mm_ctl.run |=> mm_acc < modulus_q)
		else $error("multiplier accumulator not reduced");

	// an accepted beat keeps the input closed on the next cycle
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second input accepted while busy");

endmodule

// ===== dv/modular_exponentiation_check.sv =====
// Checker for the modular exponentiation block: watches the modulus port and both streams,
// predicts each residue and compares it with the output beats.
// Depends on mexp_pkg for the field widths.
module modular_exponentiation_check import mexp_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [BASE_W-1:0]         cfg_wdata,
	input  logic                      s_tvalid,
	input  logic                      s_tready,
	input  logic [BASE_W+EXPIN_W-1:0] s_tdata,
	input  logic                      m_tvalid,
	input  logic                      m_tready,
	input  logic [RES_W-1:0]          m_tdata,
	input  logic                      m_tuser,
	output int                        failures,
	output int                        pending,
	output int                        checked
);

	typedef struct packed {
		logic [RES_W-1:0] residue;
		logic             fault;
	} outcome_t;

	outcome_t          outcome_q[$];
	logic [BASE_W-1:0] modulus = '0;
	int                n_fail = 0;
	int                n_checked = 0;

	// square-and-multiply from the top exponent bit; operands stay below 2^32
	function automatic outcome_t power_residue(input logic [BASE_W-1:0] m,
			input logic [BASE_W-1:0] g, input logic [EXPIN_W-1:0] e);
		logic [63:0] acc;
		logic [63:0] gm;
		logic [63:0] pm;
		outcome_t    o;
		o.residue = 1;
		o.fault   = 1'b0;
		if (e == '0)
			return o;
		if (m == '0) begin
			o.residue = '0;
			o.fault   = 1'b1;
			return o;
		end
		pm  = 64'(m);
		gm  = 64'(g) % pm;
		acc = 64'd1;
		for (int i = EXPIN_W - 1; i >= 0; i--) begin
			acc = (acc * acc) % pm;
			if (e[i])
				acc = (acc * gm) % pm;
		end
		o.residue = acc[RES_W-1:0];
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		outcome_t want;
		if (!arst_n) begin
			modulus = '0;
			outcome_q.delete();
			pending <= 0;
		end else begin
			if (cfg_we)
				modulus = cfg_wdata;
			// retire the oldest expectation before queueing a new one
			if (m_tvalid && m_tready) begin
				if (outcome_q.size() == 0) begin
					$error("result beat with nothing expected: residue %h error %b",
						m_tdata, m_tuser);
					n_fail++;
				end else begin
					want = outcome_q.pop_front();
					n_checked++;
					if (m_tdata !== want.residue) begin
						$error("residue: expected %h, got %h", want.residue, m_tdata);
						n_fail++;
					end
					if (m_tuser !== want.fault) begin
						$error("error: expected %b, got %b", want.fault, m_tuser);
						n_fail++;
					end
				end
			end
			if (s_tvalid && s_tready)
				outcome_q.push_back(power_residue(modulus, s_tdata[BASE_W-1:0],
					s_tdata[BASE_W +: EXPIN_W]));
			pending  <= outcome_q.size();
			failures <= n_fail;
			checked  <= n_checked;
		end
	end

endmodule

// ===== dv/modular_exponentiation_test.sv =====
// Top of the modular exponentiation testbench: clock, reset, modulus writes and stimulus.
// Depends on mexp_pkg, the block and modular_exponentiation_check.
module modular_exponentiation_test;
	import mexp_pkg::*;

	// the long hold-off spans several items
	localparam int HOLD_CYCLES = 15000;
	localparam int STALL_LIMIT = 60000;
	localparam int TAIL_CYCLES = 4500;
	localparam int RANDOM_SETS = 11;
	localparam int SET_ITEMS   = 10;
	localparam int CALM_SETS   = 2;
	localparam int HOLD_AFTER  = 35;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [BASE_W-1:0]         cfg_wdata = '0;
	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	logic [BASE_W+EXPIN_W-1:0] s_tdata = '0;   // [31:0] base, [95:32] exponent
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	logic [RES_W-1:0]          m_tdata;         // [31:0] residue
	logic                      m_tuser;         // [0] error

	int                failures;
	int                pending;
	int                checked;
	int                items_sent = 0;
	int                directed_items = 0;
	int                settings_used = 0;
	bit                calm = 1'b0;        // last part of the run: no idling on either side
	bit                hold_done = 1'b0;
	logic [BASE_W-1:0] modulus_now = '0;

	always #1 clk = ~clk;

	modular_exponentiation dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	modular_exponentiation_check checker_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.failures (failures),
		.pending  (pending),
		.checked  (checked)
	);

	// Offer one beat and hold it until the block takes it, then maybe leave a gap.
	// Valid stays high when no gap follows, so the next beat is offered without a gap.
	task automatic send_beat(input logic [BASE_W-1:0] b, input logic [EXPIN_W-1:0] e);
		s_tdata  <= {e, b};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		if (!calm && $urandom_range(0, 2) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	// Drop valid and wait until every expected result has been taken.
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Write the modulus only once the block has gone idle.
	task automatic set_modulus(input logic [BASE_W-1:0] v);
		drain();
		cfg_wdata <= v;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we      <= 1'b0;
		modulus_now = v;
		settings_used++;
	endtask

	function automatic logic [BASE_W-1:0] pick_modulus();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return 32'd1;
			2:       return '1;
			3:       return 32'($urandom_range(2, 255));
			4:       return 32'h8000_0000 | $urandom();
			default: return $urandom();
		endcase
	endfunction

	// Mostly random operands, with a share of edge values: zero, one, all ones,
	// a base that is a multiple of the modulus and single-bit or short exponents.
	task automatic send_random();
		logic [BASE_W-1:0]  b;
		logic [EXPIN_W-1:0] e;
		case ($urandom_range(0, 9))
			0:       b = '0;
			1:       b = '1;
			2:       b = 32'd1;
			3:       b = modulus_now;
			4:       b = modulus_now - 32'd1;
			default: b = $urandom();
		endcase
		case ($urandom_range(0, 9))
			0:       e = '0;
			1:       e = '1;
			2:       e = 64'd1 << $urandom_range(0, EXPIN_W - 1);
			3:       e = 64'($urandom_range(1, 20));
			default: e = {$urandom(), $urandom()};
		endcase
		send_beat(b, e);
	endtask

	// Receiver: random ready bursts, one long hold-off once results are flowing so
	// the output register and the finished item behind it both fill and the input
	// stalls, then steady ready for the last part of the run.
	initial begin : receiver
		forever begin
			if (!hold_done && !calm && checked >= HOLD_AFTER) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end
	end

	// Watchdog: end the run when no beat and no modulus write has moved for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: nothing moved for %0d cycles, %0d results outstanding",
			STALL_LIMIT, pending);
		$display("[modular_exponentiation] ERROR");
		$finish;
	end

	initial begin : stimulus
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// modulus still at its reset value of zero: zero exponent gives one,
		// anything else raises the error flag
		send_beat(32'h0, 64'h0);
		send_beat('1, 64'h0);
		send_beat(32'h5, 64'h1);
		send_beat('1, '1);

		// modulus one: residue zero unless the exponent is zero
		set_modulus(32'd1);
		send_beat(32'h7, 64'h0);
		send_beat(32'h7, 64'h5);
		send_beat('1, '1);

		// largest modulus, field extremes and a lone top exponent bit
		set_modulus('1);
		send_beat(32'h0, 64'h1);
		send_beat(32'h0, 64'h0);
		send_beat('1, '1);
		send_beat(32'h1, '1);
		send_beat(32'h2, 64'h8000_0000_0000_0000);
		send_beat(32'hDEAD_BEEF, 64'h1);

		// largest 32-bit prime
		set_modulus(32'hFFFF_FFFB);
		send_beat(32'h5, '1);
		send_beat('1, 64'h2);
		send_beat(32'hDEAD_BEEF, 64'hA5A5_5A5A_0F0F_F0F0);

		// small key-exchange style modulus, base reduced to zero and above it
		set_modulus(32'd23);
		send_beat(32'h5, 64'd6);
		send_beat(32'h5, 64'd15);
		send_beat(32'd23, 64'd3);
		send_beat(32'd24, 64'd7);
		directed_items = items_sent;

		for (int k = 0; k < RANDOM_SETS; k++) begin
			if (k >= RANDOM_SETS - CALM_SETS)
				calm = 1'b1;
			set_modulus(pick_modulus());
			repeat (SET_ITEMS) send_random();
		end

		calm = 1'b1;
		drain();
		// watch for stray result beats after the last expected one
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d input beats (%0d directed) over %0d modulus writes, %0d results",
			items_sent, directed_items, settings_used, checked);
		$display("long output hold-off %s", hold_done ? "exercised" : "not reached");
		if (failures == 0 && pending == 0)
			$display("[modular_exponentiation] OK");
		else
			$display("[modular_exponentiation] ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/mexp_pkg.sv
sv/mexp_mulmod.sv
sv/modular_exponentiation.sv
dv/modular_exponentiation_check.sv
dv/modular_exponentiation_test.sv
